// File: rtl/text_console_glyph_renderer_unit_assert.svh
// Assertion macros for the text console glyph renderer.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TCGR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tcgr: same-cycle check failed");

// Next-cycle implication.
`define TCGR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tcgr: next-cycle check failed");

`endif

// File: rtl/tcgr_pkg.sv
// Shared types and constants of the text console glyph renderer.
// No dependencies.
package tcgr_pkg;

	localparam int POS_W   = 11;  // cursor coordinate width
	localparam int ROW_W   = 4;   // glyph row index width
	localparam int ROW_MAX = 16;  // rows per glyph in the store
	localparam int ADDR_W  = 32;
	localparam int COLOR_W = 16;
	localparam int CHAR_W  = 8;
	localparam int PIX_N   = 8;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_PRINT = 1'b1;

	localparam logic [CHAR_W-1:0] CH_NUL      = 8'h00;
	localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_CTRL_MAX = 8'h1F;
	localparam logic [CHAR_W-1:0] CH_DEL      = 8'h7F;

	localparam logic [1:0] REG_FRAME_BASE = 2'd0;
	localparam logic [1:0] REG_BG_COLOR   = 2'd1;
	localparam logic [1:0] REG_INK_COLOR  = 2'd2;

	typedef enum logic [2:0] {
		CUR_NONE,
		CUR_ADVANCE,
		CUR_BACK,
		CUR_NEWLINE,
		CUR_CR
	} cur_op_t;

	typedef struct packed {
		logic mul;   // latch row * width
		logic base;  // addr = frame_base + 2*(col + product)
		logic step;  // addr += 2*width
	} addr_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_BASE,
		ST_ROWS,
		ST_BACK
	} st_t;

endpackage

// File: rtl/text_console_glyph_renderer_unit.sv
// Text console glyph renderer, top level: sequencer, glyph store, registers.
// Depends on tcgr_pkg, tcgr_ram, tcgr_cursor, tcgr_addr_unit and the assert header.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------
//  in      | sink      | in_valid / in_ready    | cmd, char_code, glyph_row, row_bits
//  out     | source    | out_valid / out_ready  | write_addr, pixel0..7, last_write
//  cfg     | sink      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A font load or a cursor-only code (LF, CR, ignored codes) is handled in the idle
// state. A drawn glyph takes a multiply, a base add, then one row write per cycle
// from the glyph store read port; output stalls hold the row sequence in place.
// Tab is four glyphs, backspace one glyph plus a final step-back state. The store
// read port and the shared address adder set the one-row-per-cycle pace. Reset
// clears the cursor, the sequencer, the frame base and the background color and
// sets the ink color to all ones; the glyph store is not cleared.
`include "text_console_glyph_renderer_unit_assert.svh"

module text_console_glyph_renderer_unit import tcgr_pkg::*; #(
	parameter int SCREEN_WIDTH  = 1680,
	parameter int SCREEN_HEIGHT = 1050,
	parameter int GLYPH_HEIGHT  = 16,
	parameter int GLYPH_COUNT   = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	// input items
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic [ROW_W-1:0]   glyph_row,
	input  logic [7:0]         row_bits,
	// row writes
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ADDR_W-1:0]  write_addr,
	output logic [COLOR_W-1:0] pixel0,
	output logic [COLOR_W-1:0] pixel1,
	output logic [COLOR_W-1:0] pixel2,
	output logic [COLOR_W-1:0] pixel3,
	output logic [COLOR_W-1:0] pixel4,
	output logic [COLOR_W-1:0] pixel5,
	output logic [COLOR_W-1:0] pixel6,
	output logic [COLOR_W-1:0] pixel7,
	output logic               last_write,
	// config writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int CODE_W = $clog2(GLYPH_COUNT);
	localparam int DEPTH  = GLYPH_COUNT * ROW_MAX;
	localparam int RA_W   = $clog2(DEPTH);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_HEIGHT - 1);
	localparam logic [CHAR_W:0]  GCOUNT   = (CHAR_W+1)'(GLYPH_COUNT);

	// ---------------- config registers ----------------
	logic [ADDR_W-1:0]  frame_base_q;
	logic [COLOR_W-1:0] bg_q, ink_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q <= '0;
			bg_q         <= '0;
			ink_q        <= '1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_BASE: frame_base_q <= cfg_data;
				REG_BG_COLOR:   bg_q         <= cfg_data[COLOR_W-1:0];
				REG_INK_COLOR:  ink_q        <= cfg_data[COLOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// ---------------- sequencer ----------------
	st_t       st_q, st_d;
	cur_op_t   cur_op;
	addr_ctl_t actl;

	logic [CHAR_W-1:0] code_q, code_d;
	logic              glyph_ok_q;
	logic [1:0]        draws_q, draws_d;  // glyphs left after the current one
	logic              back_q, back_d;    // step back once more when done
	logic [ROW_W-1:0]  row_q;
	logic              in_xfer, start, load_out, is_ctrl;
	logic              rd_en;
	logic [ROW_W-1:0]  rd_row;
	logic [7:0]        rd_data;
	logic [POS_W-1:0]  cur_col, cur_row;
	logic [ADDR_W-1:0] row_addr;

	assign in_ready = (st_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign is_ctrl  = (char_code != CH_NUL) && (char_code <= CH_CTRL_MAX);
	assign load_out = (st_q == ST_ROWS) && (!out_valid || out_ready);

	always_comb begin
		st_d    = st_q;
		cur_op  = CUR_NONE;
		actl    = '0;
		start   = 1'b0;
		code_d  = CH_NUL;
		draws_d = 2'd0;
		back_d  = 1'b0;
		rd_en   = 1'b0;
		rd_row  = row_q + ROW_W'(1);

		unique case (st_q)
			ST_IDLE: begin
				if (in_xfer && cmd == CMD_PRINT) begin
					if (is_ctrl) begin
						unique case (char_code)
							CH_BS: begin
								cur_op = CUR_BACK;
								start  = 1'b1;
								back_d = 1'b1;
							end
							CH_TAB: begin
								start   = 1'b1;
								draws_d = 2'd3;
							end
							CH_LF:   cur_op = CUR_NEWLINE;
							CH_CR:   cur_op = CUR_CR;
							default: begin
							end
						endcase
					end else if (char_code != CH_DEL) begin
						start  = 1'b1;
						code_d = char_code;
					end
				end
				if (start) begin
					st_d = ST_PREP;
				end
			end
			ST_PREP: begin
				actl.mul = 1'b1;
				st_d     = ST_BASE;
			end
			ST_BASE: begin
				actl.base = 1'b1;
				rd_en     = 1'b1;
				rd_row    = '0;
				st_d      = ST_ROWS;
			end
			ST_ROWS: begin
				if (load_out) begin
					actl.step = 1'b1;
					rd_en     = 1'b1;
					if (row_q == LAST_ROW) begin
						cur_op = CUR_ADVANCE;
						if (draws_q != 2'd0) begin
							st_d = ST_PREP;
						end else if (back_q) begin
							st_d = ST_BACK;
						end else begin
							st_d = ST_IDLE;
						end
					end
				end
			end
			ST_BACK: begin
				cur_op = CUR_BACK;
				st_d   = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// per-item context and row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draws_q <= 2'd0;
			back_q  <= 1'b0;
			row_q   <= '0;
		end else begin
			if (start) begin
				draws_q <= draws_d;
				back_q  <= back_d;
			end else if (load_out && row_q == LAST_ROW && draws_q != 2'd0) begin
				draws_q <= draws_q - 2'd1;
			end
			if (st_q == ST_PREP) begin
				row_q <= '0;
			end else if (load_out) begin
				row_q <= row_q + ROW_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			code_q     <= code_d;
			glyph_ok_q <= ({1'b0, code_d} < GCOUNT);
		end
	end

	// ---------------- glyph store ----------------
	tcgr_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (in_xfer && cmd == CMD_LOAD && ({1'b0, char_code} < GCOUNT)),
		.wr_addr (RA_W'({char_code[CODE_W-1:0], glyph_row})),
		.wr_data (row_bits),
		.rd_en   (rd_en),
		.rd_addr (RA_W'({code_q[CODE_W-1:0], rd_row})),
		.rd_data (rd_data)
	);

	// ---------------- cursor and address ----------------
	tcgr_cursor #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.GLYPH_HEIGHT  (GLYPH_HEIGHT)
	) u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (cur_op),
		.col    (cur_col),
		.row    (cur_row)
	);

	tcgr_addr_unit #(
		.SCREEN_WIDTH (SCREEN_WIDTH)
	) u_addr (
		.clk        (clk),
		.ctl        (actl),
		.frame_base (frame_base_q),
		.col        (cur_col),
		.row        (cur_row),
		.addr       (row_addr)
	);

	// ---------------- output register ----------------
	// Holds one row write; a new row loads when the slot is empty or the
	// current transfer completes in the same cycle.
	logic               out_valid_q, last_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [COLOR_W-1:0] pix_q [PIX_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			addr_q <= row_addr;
			last_q <= (row_q == LAST_ROW) && (draws_q == 2'd0);
			for (int k = 0; k < PIX_N; k++) begin
				pix_q[k] <= (glyph_ok_q && rd_data[k]) ? ink_q : bg_q;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign write_addr = addr_q;
	assign last_write = last_q;
	assign pixel0     = pix_q[0];
	assign pixel1     = pix_q[1];
	assign pixel2     = pix_q[2];
	assign pixel3     = pix_q[3];
	assign pixel4     = pix_q[4];
	assign pixel5     = pix_q[5];
	assign pixel6     = pix_q[6];
	assign pixel7     = pix_q[7];

	// ---------------- assertions ----------------
	// rows other than the final row of a glyph are never marked last
	`TCGR_ASSERT_NXT(a_last_only_at_end, load_out && (row_q != LAST_ROW), !last_write)
	// a font load never starts a draw sequence
	`TCGR_ASSERT_NXT(a_load_stays_idle, in_xfer && (cmd == CMD_LOAD), st_q == ST_IDLE)
	// row sequencing always starts from the top row
	`TCGR_ASSERT_NXT(a_rows_from_top, st_q == ST_BASE, (st_q == ST_ROWS) && (row_q == '0))

endmodule

// File: rtl/tcgr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/tcgr_cursor.sv
// Pixel cursor of the console: advance, step back, newline, carriage return.
// Depends on tcgr_pkg.
module tcgr_cursor import tcgr_pkg::*; #(
	parameter int SCREEN_WIDTH  = 1680,
	parameter int SCREEN_HEIGHT = 1050,
	parameter int GLYPH_HEIGHT  = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cur_op_t          op,
	output logic [POS_W-1:0] col,
	output logic [POS_W-1:0] row
);

	localparam int TEXT_ROWS = (SCREEN_HEIGHT / GLYPH_HEIGHT == 0) ? 1
		: SCREEN_HEIGHT / GLYPH_HEIGHT;
	localparam logic [POS_W:0]   LAST_ROW = (POS_W+1)'((TEXT_ROWS - 1) * GLYPH_HEIGHT);
	localparam logic [POS_W:0]   GH       = (POS_W+1)'(GLYPH_HEIGHT);
	localparam logic [POS_W+1:0] WIDTH    = (POS_W+2)'(SCREEN_WIDTH);

	logic [POS_W-1:0] col_q, row_q, col_d, row_d;
	logic [POS_W:0]   row_next, row_prev;
	logic [POS_W+1:0] col_adv, col_back;

	always_comb begin
		row_next = {1'b0, row_q} + GH;
		if (row_next > LAST_ROW) begin
			row_next = '0;
		end
		row_prev = ({1'b0, row_q} < GH) ? LAST_ROW : ({1'b0, row_q} - GH);
		col_adv  = {2'b00, col_q} + (POS_W+2)'(8);
		col_back = (col_q < POS_W'(8)) ? (WIDTH - (POS_W+2)'(8))
			: ({2'b00, col_q} - (POS_W+2)'(8));

		col_d = col_q;
		row_d = row_q;
		unique case (op)
			CUR_ADVANCE: begin
				if (col_adv + (POS_W+2)'(8) >= WIDTH) begin
					col_d = '0;
					row_d = row_next[POS_W-1:0];
				end else begin
					col_d = col_adv[POS_W-1:0];
				end
			end
			CUR_BACK: begin
				col_d = col_back[POS_W-1:0];
				if (col_q < POS_W'(8)) begin
					row_d = row_prev[POS_W-1:0];
				end
			end
			CUR_NEWLINE: begin
				col_d = '0;
				row_d = row_next[POS_W-1:0];
			end
			CUR_CR: begin
				col_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	assign col = col_q;
	assign row = row_q;

endmodule

// File: rtl/tcgr_addr_unit.sv
// Framebuffer address unit: one multiply for the row offset, then one shared
// adder forms the glyph base address and steps it one scan line per row.
// Depends on tcgr_pkg.
module tcgr_addr_unit import tcgr_pkg::*; #(
	parameter int SCREEN_WIDTH = 1680
) (
	input  logic              clk,
	input  addr_ctl_t         ctl,
	input  logic [ADDR_W-1:0] frame_base,
	input  logic [POS_W-1:0]  col,
	input  logic [POS_W-1:0]  row,
	output logic [ADDR_W-1:0] addr
);

	localparam int PROD_W = POS_W + $clog2(SCREEN_WIDTH + 1);
	localparam logic [ADDR_W-1:0] LINE_STEP = ADDR_W'(2 * SCREEN_WIDTH);

	logic [PROD_W-1:0] prod_q;
	logic [ADDR_W-1:0] addr_q, pix_off, op_a, op_b;

	always_comb begin
		pix_off = ADDR_W'(col) + ADDR_W'(prod_q);
		op_a    = ctl.base ? frame_base : addr_q;
		op_b    = ctl.base ? {pix_off[ADDR_W-2:0], 1'b0} : LINE_STEP;
	end

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_q <= PROD_W'(row) * PROD_W'(SCREEN_WIDTH);
		end
		if (ctl.base || ctl.step) begin
			addr_q <= op_a + op_b;
		end
	end

	assign addr = addr_q;

endmodule

// File: dv/text_console_glyph_renderer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for text_console_glyph_renderer_unit: font loads, printed
// characters and control codes, checked row write by row write. Needs tcgr_pkg and the RTL.
module testbench;
	import tcgr_pkg::*;

	localparam int SCREEN_W  = 1680;
	localparam int SCREEN_H  = 1050;
	localparam int GLYPH_H   = 16;
	localparam int GLYPH_N   = 256;
	// top y of the last text row that fits on screen
	localparam int LAST_ROW  = (SCREEN_H / GLYPH_H - 1) * GLYPH_H;
	localparam int CELL_W    = 8;
	localparam int TAB_CELLS = 4;
	localparam logic [CHAR_W-1:0] FIRST_PRINTABLE = 8'h20;

	localparam int SETTLE_CYCLES  = 24;   // settle time for a trailing load or cursor-only code
	localparam int WATCHDOG_LIMIT = 2000; // cycles with no transfer on any channel
	localparam int PHASE_ITEMS    = 60;

	typedef struct packed {
		logic [ADDR_W-1:0]             addr;
		logic [PIX_N-1:0][COLOR_W-1:0] pix;   // pix[0] is the leftmost pixel
		logic                          last;
	} row_write_t;

	// Cursor, font store and color registers as the block should hold them, plus the
	// row writes still owed for items already transferred.
	class console_tracker;
		logic [ADDR_W-1:0]  frame_base;
		logic [COLOR_W-1:0] bg_color;
		logic [COLOR_W-1:0] ink_color;
		logic [POS_W-1:0]   col;
		logic [POS_W-1:0]   row;
		logic [7:0]         font [0:GLYPH_N*ROW_MAX-1];
		bit                 font_set [0:GLYPH_N*ROW_MAX-1];
		row_write_t         pending_rows[$];
		row_write_t         batch[$];
		int                 errors;
		int                 rows_seen;

		function new();
			frame_base = '0;
			bg_color   = '0;
			ink_color  = '1;
			col        = '0;
			row        = '0;
			errors     = 0;
			rows_seen  = 0;
			foreach (font_set[i]) font_set[i] = 1'b0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] data);
			case (idx)
				REG_FRAME_BASE: frame_base = data;
				REG_BG_COLOR:   bg_color   = data[COLOR_W-1:0];
				REG_INK_COLOR:  ink_color  = data[COLOR_W-1:0];
				default: ;
			endcase
		endfunction

		// every displayed row of the glyph has been loaded
		function bit glyph_ready(logic [CHAR_W-1:0] code);
			for (int i = 0; i < GLYPH_H; i++)
				if (!font_set[{code, 4'(i)}])
					return 1'b0;
			return 1'b1;
		endfunction

		function void newline_row();
			int r;
			r = int'(row) + GLYPH_H;
			row = (r > LAST_ROW) ? '0 : POS_W'(r);
		endfunction

		function void cursor_back();
			int c;
			c = int'(col);
			if (c < CELL_W) begin
				c = SCREEN_W;
				if (int'(row) < GLYPH_H)
					row = POS_W'(LAST_ROW);
				else
					row = row - POS_W'(GLYPH_H);
			end
			col = POS_W'(c - CELL_W);
		endfunction

		function void paint_cell(logic [CHAR_W-1:0] code);
			int unsigned y;
			int unsigned pix;
			logic [7:0]  bits;
			row_write_t  w;
			for (int i = 0; i < GLYPH_H; i++) begin
				y = int'(row) + i;
				pix = int'(col) + y * SCREEN_W;
				bits = font[{code, 4'(i)}];
				w.addr = frame_base + 2 * pix;   // wraps modulo 2^32
				for (int k = 0; k < PIX_N; k++)
					w.pix[k] = bits[k] ? ink_color : bg_color;
				w.last = 1'b0;
				batch.push_back(w);
			end
			if (int'(col) + 2 * CELL_W >= SCREEN_W) begin
				col = '0;
				newline_row();
			end else begin
				col = col + POS_W'(CELL_W);
			end
		endfunction

		function void accept_item(logic c, logic [CHAR_W-1:0] code, logic [ROW_W-1:0] grow,
				logic [7:0] bits);
			row_write_t w;
			batch.delete();
			if (c == CMD_LOAD) begin
				font[{code, grow}] = bits;
				font_set[{code, grow}] = 1'b1;
				return;
			end
			if (code != CH_NUL && code <= CH_CTRL_MAX) begin
				case (code)
					CH_BS: begin
						cursor_back();
						paint_cell(CH_NUL);
						cursor_back();
					end
					CH_TAB: repeat (TAB_CELLS) paint_cell(CH_NUL);
					CH_LF: begin
						col = '0;
						newline_row();
					end
					CH_CR: col = '0;
					default: ;
				endcase
			end else if (code != CH_DEL) begin
				paint_cell(code);
			end
			if (batch.size() > 0) begin
				w = batch.pop_back();
				w.last = 1'b1;
				batch.push_back(w);
			end
			foreach (batch[i]) pending_rows.push_back(batch[i]);
		endfunction

		function void match_row_write(row_write_t got);
			row_write_t want;
			rows_seen++;
			if (pending_rows.size() == 0) begin
				errors++;
				$display("%0t: row write with none expected: addr %h", $time, got.addr);
				return;
			end
			want = pending_rows.pop_front();
			if (got.addr !== want.addr) begin
				errors++;
				$display("%0t: write_addr expected %h got %h", $time, want.addr, got.addr);
			end
			for (int k = 0; k < PIX_N; k++)
				if (got.pix[k] !== want.pix[k]) begin
					errors++;
					$display("%0t: pixel%0d expected %h got %h", $time, k, want.pix[k],
						got.pix[k]);
				end
			if (got.last !== want.last) begin
				errors++;
				$display("%0t: last_write expected %b got %b", $time, want.last, got.last);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               cmd;
	logic [CHAR_W-1:0]  char_code;
	logic [ROW_W-1:0]   glyph_row;
	logic [7:0]         row_bits;
	logic               out_valid;
	logic               out_ready;
	logic [ADDR_W-1:0]  write_addr;
	logic [COLOR_W-1:0] pixel0, pixel1, pixel2, pixel3, pixel4, pixel5, pixel6, pixel7;
	logic               last_write;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [31:0]        cfg_data;

	row_write_t     seen_row;
	console_tracker board;
	bit             gaps_on;      // random idling on both channels
	int             items_sent;
	int             loads_sent;
	int             settings_used;
	int             idle_cycles;
	logic [CHAR_W-1:0] printable[$];   // codes whose glyph is fully loaded
	bit                listed [0:GLYPH_N-1];

	text_console_glyph_renderer_unit #(
		.SCREEN_WIDTH (SCREEN_W),
		.SCREEN_HEIGHT(SCREEN_H),
		.GLYPH_HEIGHT (GLYPH_H),
		.GLYPH_COUNT  (GLYPH_N)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.char_code (char_code),
		.glyph_row (glyph_row),
		.row_bits  (row_bits),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.write_addr(write_addr),
		.pixel0    (pixel0),
		.pixel1    (pixel1),
		.pixel2    (pixel2),
		.pixel3    (pixel3),
		.pixel4    (pixel4),
		.pixel5    (pixel5),
		.pixel6    (pixel6),
		.pixel7    (pixel7),
		.last_write(last_write),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	assign seen_row = {write_addr, pixel7, pixel6, pixel5, pixel4, pixel3, pixel2, pixel1,
		pixel0, last_write};

	// Sampled in the active region of the edge, so these are the pre-edge values.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.match_row_write(seen_row);
	end

	// Watchdog: the run is stuck once no channel has moved a transfer for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: timeout, no transfer for %0d cycles", $time, idle_cycles);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Row write side: ready drops for bursts of random length while gaps are on.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (gaps_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// One input transfer. Valid stays high across back-to-back items and is only
	// dropped for a sender gap or a drain.
	task automatic send_item(input logic c, input logic [CHAR_W-1:0] code,
			input logic [ROW_W-1:0] grow, input logic [7:0] bits);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= c;
		char_code <= code;
		glyph_row <= grow;
		row_bits  <= bits;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.accept_item(c, code, grow, bits);
		items_sent++;
		if (c == CMD_LOAD) begin
			loads_sent++;
			if (!listed[code] && board.glyph_ready(code)) begin
				listed[code] = 1'b1;
				printable.push_back(code);
			end
		end
	endtask

	task automatic load_glyph(input logic [CHAR_W-1:0] code);
		for (int i = 0; i < GLYPH_H; i++)
			send_item(CMD_LOAD, code, 4'(i), 8'($urandom_range(0, 255)));
	endtask

	// Stop sending, let every owed row write arrive, then give a trailing load or
	// cursor-only code time to finish.
	task automatic drain_rows();
		in_valid <= 1'b0;
		while (board.pending_rows.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only called with the block idle. Valid stays up across the three transfers.
	task automatic program_regs(input logic [31:0] base, input logic [15:0] bg,
			input logic [15:0] ink);
		logic [1:0]  regs [3];
		logic [31:0] vals [3];
		regs[0] = REG_FRAME_BASE;
		regs[1] = REG_BG_COLOR;
		regs[2] = REG_INK_COLOR;
		vals[0] = base;
		vals[1] = 32'(bg);
		vals[2] = 32'(ink);
		cfg_valid <= 1'b1;
		for (int i = 0; i < 3; i++) begin
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			board.set_reg(regs[i], vals[i]);
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [CHAR_W-1:0] pick_control();
		case ($urandom_range(0, 5))
			0: return CH_BS;
			1: return CH_TAB;
			2: return CH_LF;
			3: return CH_CR;
			4: return CH_DEL;
			default: return CHAR_W'($urandom_range(1, CH_CTRL_MAX));
		endcase
	endfunction

	// A code that draws: NUL, printable ASCII or the upper half.
	function automatic logic [CHAR_W-1:0] pick_drawn();
		logic [CHAR_W-1:0] code;
		code = CHAR_W'($urandom_range(FIRST_PRINTABLE, 255));
		return (code == CH_DEL) ? CH_NUL : code;
	endfunction

	// Mostly text made of loaded glyphs, with whole-glyph loads, stray font row
	// writes, control codes and the odd full drain mixed in.
	task automatic run_phase(input int n, input bit quiet);
		int done;
		int r;
		done = 0;
		gaps_on = !quiet;
		while (done < n) begin
			if (!quiet && $urandom_range(0, 29) == 0)
				gaps_on = !gaps_on;
			r = $urandom_range(0, 99);
			if (r < 10) begin
				load_glyph(pick_drawn());
				done += GLYPH_H;
			end else if (r < 18) begin
				send_item(CMD_LOAD, CHAR_W'($urandom_range(0, 255)),
					ROW_W'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
				done++;
			end else if (r < 32) begin
				send_item(CMD_PRINT, pick_control(), ROW_W'($urandom_range(0, 15)),
					8'($urandom_range(0, 255)));
				done++;
			end else if (r < 34) begin
				drain_rows();
			end else begin
				send_item(CMD_PRINT, printable[$urandom_range(0, printable.size() - 1)],
					ROW_W'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
				done++;
			end
		end
	endtask

	initial begin
		board         = new();
		clk           = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		cmd           = CMD_LOAD;
		char_code     = '0;
		glyph_row     = '0;
		row_bits      = '0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_FRAME_BASE;
		cfg_data      = '0;
		gaps_on       = 1'b1;
		items_sent    = 0;
		loads_sent    = 0;
		settings_used = 1;   // reset values are the first setting
		idle_cycles   = 0;
		foreach (listed[i]) listed[i] = 1'b0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Glyph 0 backs tab and backspace: walking one and walking zero rows.
		// Glyph FF alternates all-ink and all-background rows.
		for (int i = 0; i < GLYPH_H; i++)
			send_item(CMD_LOAD, CH_NUL, 4'(i),
				i[0] ? 8'(1 << i[3:1]) : ~8'(1 << i[3:1]));
		for (int i = 0; i < GLYPH_H; i++)
			send_item(CMD_LOAD, 8'hFF, 4'(i), i[0] ? 8'h00 : 8'hFF);

		// Backspace at the top-left wraps up to the last text row, rightmost cell;
		// the blank it draws wraps the cursor back to the origin, then it steps back.
		send_item(CMD_PRINT, CH_BS, '0, '0);
		// a glyph in the last cell wraps both column and text row
		send_item(CMD_PRINT, CH_NUL, '1, '1);
		send_item(CMD_PRINT, CH_NUL, '0, '0);
		send_item(CMD_PRINT, 8'hFF, '0, '0);
		send_item(CMD_PRINT, CH_TAB, '0, '0);
		send_item(CMD_PRINT, CH_LF, '0, '0);
		send_item(CMD_PRINT, 8'hFF, '0, '0);
		send_item(CMD_PRINT, CH_CR, '0, '0);
		send_item(CMD_PRINT, CH_DEL, '0, '0);
		send_item(CMD_PRINT, CHAR_W'(1), '0, '0);
		send_item(CMD_PRINT, CH_CTRL_MAX, '0, '0);
		send_item(CMD_PRINT, CH_BS, '0, '0);
		send_item(CMD_PRINT, CH_NUL, '0, '0);

		// Register settings, extremes first; the last phase runs with no idling.
		drain_rows();
		program_regs(32'hFFFF_FFFF, 16'hFFFF, 16'h0000);
		run_phase(PHASE_ITEMS, 1'b0);
		drain_rows();
		program_regs(32'h0000_0000, 16'h0000, 16'hFFFF);
		run_phase(PHASE_ITEMS, 1'b0);
		drain_rows();
		program_regs($urandom, 16'($urandom), 16'($urandom));
		run_phase(PHASE_ITEMS, 1'b0);
		drain_rows();
		program_regs({1'b1, 31'($urandom)}, 16'($urandom), 16'($urandom));
		run_phase(PHASE_ITEMS, 1'b1);
		drain_rows();

		$display("Covered %0d input transfers (%0d font row loads) over %0d color/base settings",
			items_sent, loads_sent, settings_used);
		$display("Checked %0d row writes, %0d field mismatches", board.rows_seen, board.errors);
		if (board.errors == 0 && board.pending_rows.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/tcgr_pkg.sv
rtl/tcgr_ram.sv
rtl/tcgr_cursor.sv
rtl/tcgr_addr_unit.sv
rtl/text_console_glyph_renderer_unit.sv
dv/text_console_glyph_renderer_unit_tb.sv
